// ----- rtl/ddrw_pkg.sv -----
// Package for the decimal digit register writer.
// Widths, digit vector type and converter state encoding.
// No dependencies.
package ddrw_pkg;

  localparam int NUM_W   = 32;                // binary input width
  localparam int NDIG    = 10;                // decimal digits of a 32-bit value
  localparam int DIG_W   = 4;                 // one BCD digit
  localparam int POS_W   = 4;                 // digit position 1..NDIG
  localparam int CNT_W   = $clog2(NUM_W);     // shift counter
  localparam int MIN_W   = 4;                 // min_digits register
  localparam logic [MIN_W-1:0] MIN_RST = MIN_W'(7);

  typedef logic [NDIG-1:0][DIG_W-1:0] digit_vec_t;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_SHIFT,
    CV_HOLD
  } conv_state_t;

endpackage

// ----- rtl/ddrw_cell.sv -----
// One BCD cell of the shift-add-3 chain.
// Holds a digit, adjusts and shifts one bit in from its lower neighbor.
// Depends on ddrw_pkg.
module ddrw_cell
  import ddrw_pkg::*;
(
  input  logic             clk,
  input  logic             clr,
  input  logic             en,
  input  logic             bit_in,
  output logic             carry_out,
  output logic [DIG_W-1:0] digit
);

  logic [DIG_W-1:0] digit_r;
  logic [DIG_W-1:0] digit_nxt;
  logic [DIG_W-1:0] adj;

  // add 3 when >= 5 so the shift carries into the next decade
  assign adj       = (digit_r >= DIG_W'(5)) ? digit_r + DIG_W'(3) : digit_r;
  assign carry_out = adj[DIG_W-1];
  assign digit     = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (clr) begin
      digit_nxt = '0;
    end else if (en) begin
      digit_nxt = {adj[DIG_W-2:0], bit_in};
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

// ----- rtl/ddrw_conv.sv -----
// Binary to BCD converter: a row of ddrw_cell digits fed one bit per cycle.
// Start loads a number; after NUM_W shifts the digits hold until taken.
// Depends on ddrw_pkg and ddrw_cell.
module ddrw_conv
  import ddrw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] number,
  output logic             ready,
  output logic             done,
  input  logic             take,
  output digit_vec_t       digits
);

  conv_state_t      state_r, state_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             clr, shift_en;
  logic [NDIG:0]    chain;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CV_IDLE:  if (start) state_nxt = CV_SHIFT;
      CV_SHIFT: if (cnt_r == '0) state_nxt = CV_HOLD;
      CV_HOLD:  if (take) state_nxt = CV_IDLE;
      default:  state_nxt = CV_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ready    = 1'b0;
    done     = 1'b0;
    shift_en = 1'b0;
    case (state_r)
      CV_IDLE:  ready    = 1'b1;
      CV_SHIFT: shift_en = 1'b1;
      CV_HOLD:  done     = 1'b1;
      default:  ready    = 1'b0;
    endcase
  end

  assign clr = ready & start;

  always_comb begin
    num_nxt = num_r;
    cnt_nxt = cnt_r;
    if (clr) begin
      num_nxt = number;
      cnt_nxt = CNT_W'(NUM_W - 1);
    end else if (shift_en) begin
      num_nxt = {num_r[NUM_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    num_r <= num_nxt;
    cnt_r <= cnt_nxt;
  end

  assign chain[0] = num_r[NUM_W-1];

  genvar g;
  generate
    for (g = 0; g < NDIG; g++) begin : g_cell
      ddrw_cell u_cell (
        .clk       (clk),
        .clr       (clr),
        .en        (shift_en),
        .bit_in    (chain[g]),
        .carry_out (chain[g+1]),
        .digit     (digits[g])
      );
    end
  endgenerate

  // top decade never exceeds 4 for a 32-bit value, so it never carries out
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CV_SHIFT) |-> !chain[NDIG])
    else $error("BCD chain overflow");

  a_hold_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (done && take) |=> ready)
    else $error("converter did not release after take");

  a_start_shifts: assert property (@(posedge clk) disable iff (!rst_n)
    (ready && start) |=> (state_r == CV_SHIFT && cnt_r == CNT_W'(NUM_W - 1)))
    else $error("converter did not start shifting");

endmodule

// ----- rtl/decimal_digit_register_writer.sv -----
// Decimal digit register writer: number in, digit register writes out.
// Path: bit-serial conversion in the BCD cell chain, then a hand-off of the digits to the write
//   buffer, whose registers drive the first write.
// Overlap: the cell chain converts one bit per cycle; the writes of one number (up to 10, one
//   per cycle unless out_tready stalls them) overlap the next conversion.
// Reset: synchronous active-low; min_digits returns to 7, no write is pending.
module decimal_digit_register_writer
  import ddrw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,   // [31:0] number
  // digit write stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // [3:0] digit_position, [7:4] digit_value
  output logic             out_tlast,  // last write of this number
  // configuration
  input  logic             cfg_wr_en,
  input  logic [MIN_W-1:0] cfg_wr_data // min_digits
);

  logic [MIN_W-1:0] min_digits_r, min_digits_nxt;

  // converter handshake
  logic       conv_ready, conv_done, conv_take;
  digit_vec_t conv_digits;

  // write buffer: digit 0 always the one on the bus
  digit_vec_t       dig_buf_r, dig_buf_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] count_r, count_nxt;
  logic             active_r, active_nxt;

  logic [POS_W-1:0] sig_cnt, min_eff, run_len;
  logic             out_beat;

  always_comb begin
    min_digits_nxt = cfg_wr_en ? cfg_wr_data : min_digits_r;
  end

  ddrw_conv u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_tvalid),
    .number (in_tdata),
    .ready  (conv_ready),
    .done   (conv_done),
    .take   (conv_take),
    .digits (conv_digits)
  );

  assign in_tready = conv_ready;

  // number of significant digits: highest nonzero decade, 0 for a zero number
  always_comb begin
    sig_cnt = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (conv_digits[i] != '0) sig_cnt = POS_W'(i + 1);
    end
  end

  // minimum above ten saturates to ten
  assign min_eff = (min_digits_r > MIN_W'(NDIG)) ? POS_W'(NDIG) : POS_W'(min_digits_r);
  assign run_len = (sig_cnt > min_eff) ? sig_cnt : min_eff;

  // buffer loads only when empty; a zero-length run is just dropped
  assign conv_take = conv_done & ~active_r;
  assign out_beat  = out_tvalid & out_tready;

  always_comb begin
    dig_buf_nxt = dig_buf_r;
    pos_nxt     = pos_r;
    count_nxt   = count_r;
    active_nxt  = active_r;
    if (conv_take) begin
      dig_buf_nxt = conv_digits;
      pos_nxt     = POS_W'(1);
      count_nxt   = run_len;
      active_nxt  = (run_len != '0);
    end else if (out_beat) begin
      dig_buf_nxt = dig_buf_r >> DIG_W;
      pos_nxt     = pos_r + POS_W'(1);
      if (pos_r == count_r) active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_digits_r <= MIN_RST;
      active_r     <= 1'b0;
    end else begin
      min_digits_r <= min_digits_nxt;
      active_r     <= active_nxt;
    end
    dig_buf_r <= dig_buf_nxt;
    pos_r     <= pos_nxt;
    count_r   <= count_nxt;
  end

  assign out_tvalid = active_r;
  assign out_tdata  = {dig_buf_r[0], pos_r};
  assign out_tlast  = (pos_r == count_r);

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat && out_tlast) |=> !out_tvalid)
    else $error("write after last beat of a run");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pos_r != '0 && pos_r <= count_r && count_r <= POS_W'(NDIG)))
    else $error("digit position out of range");

  a_digit_bcd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (dig_buf_r[0] <= DIG_W'(9)))
    else $error("digit value not decimal");

  a_pos_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat && !out_tlast) |=> (out_tvalid && pos_r == $past(pos_r) + POS_W'(1)))
    else $error("digit position did not advance");

endmodule

// ----- bench/tb_decimal_digit_register_writer.sv -----
// Testbench for decimal_digit_register_writer: streams numbers in, checks every
// digit register write against a local digit predictor. Depends on ddrw_pkg and the RTL.
`timescale 1ns / 100ps

module tb_decimal_digit_register_writer;
  import ddrw_pkg::*;

  localparam int unsigned RADIX        = 10;   // decimal
  localparam int unsigned SETTLE_CYCLES = 40;  // conversion latency plus margin
  localparam int unsigned STALL_LIMIT  = 1000; // cycles with no beat on any channel
  localparam int unsigned RANDOM_PER_PHASE = 26;

  // One digit register write as it leaves the block.
  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [DIG_W-1:0] value;
    logic             last;
  } digit_write_t;

  // Receiver behavior, re-picked after each random stretch.
  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_PATTERN
  } ready_mode_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [31:0]      in_tdata;     // [31:0] number
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [7:0]       out_tdata;    // [3:0] digit_position, [7:4] digit_value
  logic             out_tlast;
  logic             cfg_wr_en;
  logic [MIN_W-1:0] cfg_wr_data;  // min_digits

  // Predictor state: shadow of min_digits and the writes still owed by the block.
  logic [MIN_W-1:0] min_digits_shadow = MIN_RST;
  digit_write_t     owed_writes[$];
  int unsigned      failure_count = 0;

  decimal_digit_register_writer DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Digit predictor: splits a number into decimal digits, LSD first, padded with
  // zeros up to min_digits (clamped to ten), and queues the writes it owes.
  function automatic void queue_digit_writes(input logic [NUM_W-1:0] number);
    logic [NUM_W-1:0] rest;
    int unsigned      floor_len;
    int unsigned      pos;
    digit_write_t     wr;
    rest      = number;
    floor_len = (min_digits_shadow > NDIG) ? NDIG : min_digits_shadow;
    pos       = 1;
    // zero with no minimum falls straight through: nothing owed
    while ((rest != 0 || pos <= floor_len) && pos <= NDIG) begin
      wr.position = POS_W'(pos);
      wr.value    = DIG_W'(rest % RADIX);
      rest        = rest / RADIX;
      wr.last     = (rest == 0 && pos >= floor_len) || pos >= NDIG;
      owed_writes.push_back(wr);
      pos++;
    end
  endfunction

  // Checker: sampled at the rising edge. Outputs are checked before the input
  // beat of the same edge is predicted; a new number cannot produce a write
  // in the cycle it is taken.
  always @(posedge clk) begin
    digit_write_t exp_wr;
    if (!rst_n) begin
      min_digits_shadow = MIN_RST;
    end else begin
      if (out_tvalid && out_tready) begin
        if (owed_writes.size() == 0) begin
          $error("unexpected digit write: position %0d value %0d last %0b",
                 out_tdata[3:0], out_tdata[7:4], out_tlast);
          failure_count++;
        end else begin
          exp_wr = owed_writes.pop_front();
          if (out_tdata[3:0] !== exp_wr.position) begin
            $error("digit_position: expected %0d, got %0d", exp_wr.position, out_tdata[3:0]);
            failure_count++;
          end
          if (out_tdata[7:4] !== exp_wr.value) begin
            $error("digit_value: expected %0d, got %0d", exp_wr.value, out_tdata[7:4]);
            failure_count++;
          end
          if (out_tlast !== exp_wr.last) begin
            $error("last: expected %0b, got %0b", exp_wr.last, out_tlast);
            failure_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        queue_digit_writes(in_tdata);
      if (cfg_wr_en)
        min_digits_shadow = cfg_wr_data;
    end
  end

  // Receiver: tready changes at the falling edge. Modes run for random
  // stretches; always-ready stretches leave the block unthrottled.
  ready_mode_t ready_mode = RDY_ALWAYS;
  int unsigned ready_stretch = 0;
  logic [15:0] ready_pattern = 16'hFFFF;

  always @(negedge clk) begin
    if (ready_stretch == 0) begin
      ready_mode    = ready_mode_t'($urandom_range(0, 2));
      ready_stretch = $urandom_range(20, 120);
      // keep a one in each byte of the pattern so no stall spans a whole byte
      ready_pattern = 16'($urandom()) | 16'h0101;
    end else begin
      ready_stretch--;
    end
    case (ready_mode)
      RDY_ALWAYS: begin
        out_tready <= 1'b1;
      end
      RDY_RANDOM: begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_tready    <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      end
    endcase
  end

  // Watchdog: ends the run if no beat moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_decimal_digit_register_writer: FAIL");
    $finish;
  end

  // One number beat: data set at the falling edge, held until taken.
  // tvalid stays high afterwards; idle_sender lowers it.
  task automatic send_number(input logic [NUM_W-1:0] number);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= number;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Stop sending and let every owed write come out.
  task automatic drain_writes();
    idle_sender(1);
    while (owed_writes.size() != 0) @(posedge clk);
  endtask

  // Register write only with the block idle: a zero with no minimum owes
  // nothing, so give a possible conversion in flight time to finish.
  task automatic write_min_digits(input logic [MIN_W-1:0] min_digits);
    drain_writes();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= min_digits;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Reset default of seven: short numbers padded, long ones not.
  task automatic test_reset_default();
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'd12345);
    send_number(32'd9999999);
    send_number(32'd10000000);
    send_number(32'hFFFF_FFFF);
  endtask

  // Minimum setting extremes, zero with no minimum, and minimums above ten.
  task automatic test_min_digits_settings();
    write_min_digits(MIN_W'(0));
    send_number(32'd0);           // no writes at all
    send_number(32'd5);
    write_min_digits(MIN_W'(15)); // clamps to ten
    send_number(32'd0);
    send_number(32'hFFFF_FFFF);
    write_min_digits(MIN_W'(11));
    send_number(32'd0);
    write_min_digits(MIN_W'(10));
    send_number(32'd1);
    write_min_digits(MIN_W'(1));
    send_number(32'd0);
    send_number(32'd1000000000);
  endtask

  // Digit-count boundaries and the top of the input range.
  task automatic test_digit_extremes();
    write_min_digits(MIN_W'(3));
    send_number(32'd9);
    send_number(32'd10);
    send_number(32'd99);
    send_number(32'd100);
    send_number(32'd999999999);
    send_number(32'd1000000000);
    send_number(32'h8000_0000);
    send_number(32'hFFFF_FFFE);
  endtask

  // Numbers biased toward digit-count edges, zeros and the top of the range.
  function automatic logic [NUM_W-1:0] pick_number();
    int unsigned scale;
    int unsigned digits;
    scale  = 1;
    digits = $urandom_range(0, 9);
    repeat (digits) scale *= RADIX;
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return $urandom_range(0, 99);
      2:       return scale + $urandom_range(0, 2) - 1;
      3:       return $urandom_range(0, scale - 1);
      4:       return '0;
      default: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
    endcase
  endfunction

  // Random numbers in bursts with gaps, over several minimum settings.
  task automatic test_random_numbers();
    logic [MIN_W-1:0] phase_min[6];
    int unsigned      burst_left;
    phase_min = '{MIN_W'(0), MIN_W'(10), MIN_W'(15), MIN_W'($urandom()),
                  MIN_W'(1), MIN_W'($urandom())};
    foreach (phase_min[p]) begin
      write_min_digits(phase_min[p]);
      burst_left = $urandom_range(1, 8);
      repeat (RANDOM_PER_PHASE) begin
        send_number(pick_number());
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 8);
          if ($urandom_range(0, 9) == 0)
            drain_writes();                       // hold off until all writes are out
          else if ($urandom_range(0, 2) != 0)
            idle_sender($urandom_range(1, 12));   // else run straight into the next burst
        end
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_default();
    test_min_digits_settings();
    test_digit_extremes();
    test_random_numbers();

    // all numbers taken: wait out the owed writes, then watch for strays
    drain_writes();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (failure_count == 0)
      $display("tb_decimal_digit_register_writer: PASS");
    else
      $display("tb_decimal_digit_register_writer: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ddrw_pkg.sv
rtl/ddrw_cell.sv
rtl/ddrw_conv.sv
rtl/decimal_digit_register_writer.sv
bench/tb_decimal_digit_register_writer.sv
